// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define XPL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define XPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/xplbf_pkg.sv =====
`default_nettype none
package xplbf_pkg;

    typedef struct packed {
        logic [15:0] raw_value;
        logic [11:0] column;
        logic [11:0] row;
    } t_in;

    typedef struct packed {
        logic [23:0] line_integral;
        logic        saturated;
    } t_out;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    typedef enum logic [2:0] {
        REG_GAIN,
        REG_OFFSET,
        REG_LOG_ENABLE,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_ZERO_WIDTHS,
        REG_FEATHER_WIDTHS
    } t_reg_idx;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [23:0] OUT_MAX = 24'hFFFFFF;

endpackage
`default_nettype wire

// ===== sv/xray_pixel_log_border_feather_top.sv =====
// throughput: one pixel per cycle while the output is not stalled, set by a fully
// pipelined datapath in which the 20-step squaring log2 chain and the 17-step
// restoring weight divider each own stages
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
// reset: synchronous active-low i_rst_n clears all valid bits and loads register defaults
`default_nettype none
module xray_pixel_log_border_feather_top #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  xplbf_pkg::t_in                  i_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output xplbf_pkg::t_out                 o_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [xplbf_pkg::ADDR_W-1:0]    paddr,
    input  logic [xplbf_pkg::DATA_W-1:0]    pwdata,
    output logic [xplbf_pkg::DATA_W-1:0]    prdata,
    output logic                            pready
);
    import xplbf_pkg::*;

    localparam int NST       = 29;
    localparam int NC        = 28;
    localparam int LOG_IT    = 20;
    localparam int DIV_STEPS = 17;
    localparam int S_PREP    = 1;
    localparam int S_WGT     = 21;
    localparam int S_SEL     = 23;
    localparam int S_APPLY   = 24;
    localparam int NSIDE     = 4;

    localparam logic [12:0] SIDE_CAP = (MAX_SIDE > 8191) ? 13'd8191 : 13'(MAX_SIDE);
    localparam logic [16:0] WT_ONE   = 17'd65536;
    localparam logic [56:0] LN_RND   = 57'd1 << 35;
    localparam logic [64:0] RND16    = 65'd32768;

    typedef enum logic [1:0] {K_ZERO, K_ONE, K_BAND} t_kind;

    typedef struct packed {
        logic                   outside;
        logic                   logok;
        logic [47:0]            val;
        t_kind [NSIDE-1:0]      kind;
        logic [NSIDE-1:0][16:0] wt;
    } t_carry;

    // configuration
    logic signed [31:0] r_gain, r_offset;
    logic               r_log_en;
    logic [12:0]        r_img_w, r_img_h;
    logic [47:0]        r_zero_w, r_fthr_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= 32'sd65536;
            r_offset <= '0;
            r_log_en <= 1'b0;
            r_img_w  <= 13'd1024;
            r_img_h  <= 13'd1024;
            r_zero_w <= '0;
            r_fthr_w <= '0;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[ADDR_W-1:3]))
                REG_GAIN:           r_gain   <= pwdata[31:0];
                REG_OFFSET:         r_offset <= pwdata[31:0];
                REG_LOG_ENABLE:     r_log_en <= pwdata[0];
                REG_IMAGE_WIDTH:    r_img_w  <= pwdata[12:0];
                REG_IMAGE_HEIGHT:   r_img_h  <= pwdata[12:0];
                REG_ZERO_WIDTHS:    r_zero_w <= pwdata[47:0];
                REG_FEATHER_WIDTHS: r_fthr_w <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (t_reg_idx'(paddr[ADDR_W-1:3]))
            REG_GAIN:           prdata = {32'd0, r_gain};
            REG_OFFSET:         prdata = {32'd0, r_offset};
            REG_LOG_ENABLE:     prdata = {63'd0, r_log_en};
            REG_IMAGE_WIDTH:    prdata = {51'd0, r_img_w};
            REG_IMAGE_HEIGHT:   prdata = {51'd0, r_img_h};
            REG_ZERO_WIDTHS:    prdata = {16'd0, r_zero_w};
            REG_FEATHER_WIDTHS: prdata = {16'd0, r_fthr_w};
            default:            prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // pipeline control
    logic           en;
    logic [NST-1:0] r_vld;

    assign en      = !(r_vld[NST-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // datapath registers
    t_carry                  r_c [NC];
    logic signed [49:0]      r_v0;
    logic [NSIDE-1:0][11:0]  r_n0;
    logic [30:0]             r_py;
    logic [4:0]              r_pe;
    logic [NSIDE-1:0][23:0]  r_f2, r_n2;
    logic [NSIDE-1:0][47:0]  r_num, r_den;
    logic [NSIDE-1:0][64:0]  r_dvd;
    logic [NSIDE-1:0][47:0]  r_dv;
    logic [NSIDE-1:0][64:0]  r_rem [DIV_STEPS];
    logic [NSIDE-1:0][16:0]  r_dq  [DIV_STEPS];
    logic [NSIDE-1:0][47:0]  r_dd  [DIV_STEPS];
    logic [30:0]             r_ly  [LOG_IT];
    logic [19:0]             r_lf  [LOG_IT];
    logic [4:0]              r_le  [LOG_IT];
    logic [56:0]             r_lm;
    t_out                    r_out;

    t_carry                  n_c [NC];
    t_carry                  n_c0, n_c1;
    logic signed [49:0]      n_v0;
    logic [NSIDE-1:0][11:0]  n_n0;
    logic [30:0]             n_py;
    logic [4:0]              n_pe;
    logic [NSIDE-1:0][23:0]  n_f2, n_n2;
    logic [NSIDE-1:0][47:0]  n_num, n_den;
    logic [NSIDE-1:0][64:0]  n_dvd;
    logic [NSIDE-1:0][47:0]  n_dv;
    logic [NSIDE-1:0][64:0]  n_rem [DIV_STEPS];
    logic [NSIDE-1:0][16:0]  n_dq  [DIV_STEPS];
    logic [NSIDE-1:0][47:0]  n_dd  [DIV_STEPS];
    logic [30:0]             n_ly  [LOG_IT];
    logic [19:0]             n_lf  [LOG_IT];
    logic [4:0]              n_le  [LOG_IT];
    logic [56:0]             n_lm;
    t_out                    n_out;

    // stage 0: affine map, border distances and classification
    always_comb begin
        logic [12:0] cap_w, cap_h, col, row, b, zf;
        logic [11:0] z, f;
        cap_w = (r_img_w > SIDE_CAP) ? SIDE_CAP : r_img_w;
        cap_h = (r_img_h > SIDE_CAP) ? SIDE_CAP : r_img_h;
        col   = {1'b0, i_data.column};
        row   = {1'b0, i_data.row};
        n_v0  = $signed({1'b0, i_data.raw_value}) * r_gain + r_offset;
        n_c0         = '0;
        n_c0.outside = (col >= cap_w) || (row >= cap_h);
        for (int i = 0; i < NSIDE; i++) begin
            case (i)
                0:       b = col;
                1:       b = cap_w - col;
                2:       b = cap_h - row;
                default: b = row;
            endcase
            z  = r_zero_w[12*i +: 12];
            f  = r_fthr_w[12*i +: 12];
            zf = {1'b0, z} + {1'b0, f};
            if (b >= zf) begin
                n_c0.kind[i] = K_ONE;
            end else if (b <= {1'b0, z}) begin
                n_c0.kind[i] = K_ZERO;
            end else begin
                n_c0.kind[i] = K_BAND;
            end
            n_n0[i] = 12'(zf - b);
        end
    end

    // stage 1: log normalization, squares for the taper
    always_comb begin
        logic [16:0] k, x;
        logic [4:0]  p;
        logic [11:0] f;
        k = 17'd1;
        p = '0;
        n_c1       = r_c[S_PREP-1];
        n_c1.logok = (r_v0 > 50'sd0) && (r_v0 <= 50'sd65536);
        n_c1.val   = (r_v0 < 50'sd0) ? 48'd0 : r_v0[47:0];
        if (n_c1.logok) begin
            k = r_v0[16:0];
        end
        for (int j = 0; j < 17; j++) begin
            if (k[j]) begin
                p = 5'(j);
            end
        end
        n_pe = 5'd16 - p;
        x    = k << n_pe;
        n_py = {x, 14'd0};
        for (int i = 0; i < NSIDE; i++) begin
            f       = r_fthr_w[12*i +: 12];
            n_f2[i] = {12'd0, f} * {12'd0, f};
            n_n2[i] = {12'd0, r_n0[i]} * {12'd0, r_n0[i]};
        end
    end

    // stages 2 and 3: taper numerator, denominator and rounded dividend
    always_comb begin
        logic [23:0] dif;
        for (int i = 0; i < NSIDE; i++) begin
            dif      = r_f2[i] - r_n2[i];
            n_num[i] = {24'd0, dif} * {24'd0, dif};
            n_den[i] = {24'd0, r_f2[i]} * {24'd0, r_f2[i]};
            n_dvd[i] = {1'b0, r_num[i], 16'd0} + {17'd0, r_den[i] >> 1};
            n_dv[i]  = r_den[i];
        end
    end

    // stages 4 to 20: restoring divider, one quotient bit per stage
    always_comb begin
        logic [64:0] rem, trial;
        logic [16:0] q;
        logic [47:0] dv;
        for (int j = 0; j < DIV_STEPS; j++) begin
            for (int i = 0; i < NSIDE; i++) begin
                if (j == 0) begin
                    rem = r_dvd[i];
                    dv  = r_dv[i];
                    q   = '0;
                end else begin
                    rem = r_rem[j-1][i];
                    dv  = r_dd[j-1][i];
                    q   = r_dq[j-1][i];
                end
                trial = {17'd0, dv} << (DIV_STEPS - 1 - j);
                if (rem >= trial) begin
                    n_rem[j][i] = rem - trial;
                    n_dq[j][i]  = {q[15:0], 1'b1};
                end else begin
                    n_rem[j][i] = rem;
                    n_dq[j][i]  = {q[15:0], 1'b0};
                end
                n_dd[j][i] = dv;
            end
        end
    end

    // stages 2 to 21: log2 fraction by repeated squaring
    always_comb begin
        logic [30:0] y;
        logic [19:0] fr;
        logic [4:0]  e;
        logic [61:0] sq;
        logic [31:0] t;
        for (int i = 0; i < LOG_IT; i++) begin
            if (i == 0) begin
                y  = r_py;
                fr = '0;
                e  = r_pe;
            end else begin
                y  = r_ly[i-1];
                fr = r_lf[i-1];
                e  = r_le[i-1];
            end
            sq = {31'd0, y} * {31'd0, y};
            t  = sq[61:30];
            if (t[31]) begin
                n_ly[i] = t[31:1];
                n_lf[i] = {fr[18:0], 1'b1};
            end else begin
                n_ly[i] = t[30:0];
                n_lf[i] = {fr[18:0], 1'b0};
            end
            n_le[i] = e;
        end
    end

    // stage 22: scale log2 to natural log
    always_comb begin
        logic [24:0] l;
        l    = {r_le[LOG_IT-1], 20'd0} - {5'd0, r_lf[LOG_IT-1]};
        n_lm = {32'd0, l} * {25'd0, LN2_Q32};
    end

    // carry chain through the remaining stages
    always_comb begin
        logic [64:0] prod;
        prod          = '0;
        n_c[0]        = n_c0;
        n_c[S_PREP]   = n_c1;
        for (int s = S_PREP + 1; s < NC; s++) begin
            n_c[s] = r_c[s-1];
            if (s == S_WGT) begin
                for (int i = 0; i < NSIDE; i++) begin
                    case (r_c[s-1].kind[i])
                        K_ONE:   n_c[s].wt[i] = WT_ONE;
                        K_ZERO:  n_c[s].wt[i] = '0;
                        default: n_c[s].wt[i] = r_dq[DIV_STEPS-1][i];
                    endcase
                end
            end
            if (s == S_SEL && r_log_en) begin
                n_c[s].val = r_c[s-1].logok ? 48'((r_lm + LN_RND) >> 36) : 48'd0;
            end
            if (s >= S_APPLY) begin
                prod = {17'd0, r_c[s-1].val} * {48'd0, r_c[s-1].wt[s-S_APPLY]} + RND16;
                n_c[s].val = prod[63:16];
            end
        end
    end

    // output stage: zero for pixels outside the image, else saturate
    always_comb begin
        n_out = '0;
        if (!r_c[NC-1].outside) begin
            if (r_c[NC-1].val > {24'd0, OUT_MAX}) begin
                n_out.line_integral = OUT_MAX;
                n_out.saturated     = 1'b1;
            end else begin
                n_out.line_integral = r_c[NC-1].val[23:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c   <= n_c;
            r_v0  <= n_v0;
            r_n0  <= n_n0;
            r_py  <= n_py;
            r_pe  <= n_pe;
            r_f2  <= n_f2;
            r_n2  <= n_n2;
            r_num <= n_num;
            r_den <= n_den;
            r_dvd <= n_dvd;
            r_dv  <= n_dv;
            r_rem <= n_rem;
            r_dq  <= n_dq;
            r_dd  <= n_dd;
            r_ly  <= n_ly;
            r_lf  <= n_lf;
            r_le  <= n_le;
            r_lm  <= n_lm;
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule
`default_nettype wire

// ===== sv/xplbf_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module xplbf_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_stall,
    input wire logic            o_valid,
    input wire logic            i_stall,
    input wire xplbf_pkg::t_out o_data
);
    import xplbf_pkg::*;

    // input side only backs up when a finished result is held
    `XPL_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> (o_valid && i_stall), "stall without held result")
    // held result transaction stays put
    `XPL_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_data)), "output changed while stalled")
    `XPL_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
    `XPL_ASSERT(a_sat_max, i_clk, i_rst_n, (o_valid && o_data.saturated) |-> (o_data.line_integral == OUT_MAX), "saturated below maximum")

endmodule

bind xray_pixel_log_border_feather_top xplbf_checker u_xplbf_checker (.*);
`default_nettype wire

// ===== dv/tb_xray_pixel_log_border_feather_top.sv =====
`default_nettype none
module tb_xray_pixel_log_border_feather_top;
    import xplbf_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_in                  i_data;
    logic                 o_valid;
    logic                 i_stall;
    t_out                 o_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    xray_pixel_log_border_feather_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow copy of the register file
    logic signed [31:0] sh_gain;
    logic signed [31:0] sh_offset;
    logic               sh_log;
    logic [12:0]        sh_width;
    logic [12:0]        sh_height;
    logic [47:0]        sh_zero;
    logic [47:0]        sh_feather;

    t_out pending_pixels[$];
    int   mismatches;
    int   idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 400000);
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [63:0] minus_ln_q16(logic [63:0] k);
        int          p;
        logic [63:0] y;
        logic [63:0] frac;
        logic [63:0] l;
        p = 0;
        frac = 0;
        while (p < 16 && (k >> (p + 1)) != 0)
            p++;
        y = (k << (16 - p)) << 14;
        for (int i = 0; i < 20; i++) begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= 64'h8000_0000) begin
                y = y >> 1;
                frac = frac | 1;
            end
        end
        l = (64'(16 - p) << 20) - frac;
        return (l * 64'(LN2_Q32) + (64'd1 << 35)) >> 36;
    endfunction

    function automatic logic [63:0] taper_weight(longint b, logic [63:0] z, logic [63:0] f);
        logic [63:0] n;
        logic [63:0] f2;
        logic [63:0] num;
        logic [63:0] den;
        if (b >= longint'(z + f))
            return 64'd65536;
        if (b <= longint'(z))
            return 64'd0;
        n = 64'(longint'(z + f) - b);
        f2 = f * f;
        num = f2 - n * n;
        num = num * num;
        den = f2 * f2;
        return ((num << 16) + den / 2) / den;
    endfunction

    function automatic t_out predict_pixel(t_in px);
        t_out        r;
        longint      w;
        longint      h;
        longint      v;
        logic [63:0] val;
        logic [63:0] wt[4];
        w = (sh_width > 4096) ? 4096 : longint'(sh_width);
        h = (sh_height > 4096) ? 4096 : longint'(sh_height);
        r = '0;
        if (longint'(px.column) >= w || longint'(px.row) >= h)
            return r;
        v = longint'(px.raw_value) * longint'(sh_gain) + longint'(sh_offset);
        if (sh_log)
            val = (v <= 0 || v > 65536) ? 64'd0 : minus_ln_q16(64'(v));
        else
            val = (v < 0) ? 64'd0 : 64'(v);
        wt[0] = taper_weight(longint'(px.column), sh_zero[11:0], sh_feather[11:0]);
        wt[1] = taper_weight(w - longint'(px.column), sh_zero[23:12], sh_feather[23:12]);
        wt[2] = taper_weight(h - longint'(px.row), sh_zero[35:24], sh_feather[35:24]);
        wt[3] = taper_weight(longint'(px.row), sh_zero[47:36], sh_feather[47:36]);
        for (int i = 0; i < 4; i++)
            val = (val * wt[i] + (64'd1 << 15)) >> 16;
        if (val > 64'(OUT_MAX)) begin
            r.line_integral = OUT_MAX;
            r.saturated = 1'b1;
        end else begin
            r.line_integral = val[23:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", o_data);
            end else begin
                t_out want;
                want = pending_pixels.pop_front();
                if (o_data.line_integral !== want.line_integral
                        || o_data.saturated !== want.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b actual %h/%b",
                                 want.line_integral, want.saturated,
                                 o_data.line_integral, o_data.saturated);
                end
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * int'(idx));
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_GAIN:           sh_gain = value[31:0];
            REG_OFFSET:         sh_offset = value[31:0];
            REG_LOG_ENABLE:     sh_log = value[0];
            REG_IMAGE_WIDTH:    sh_width = value[12:0];
            REG_IMAGE_HEIGHT:   sh_height = value[12:0];
            REG_ZERO_WIDTHS:    sh_zero = value[47:0];
            REG_FEATHER_WIDTHS: sh_feather = value[47:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(logic [15:0] raw, logic [11:0] col, logic [11:0] row);
        t_in px;
        px.raw_value = raw;
        px.column = col;
        px.row = row;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= px;
        do @(posedge i_clk); while (o_stall);
        pending_pixels.push_back(predict_pixel(px));
    endtask

    // valid drops in the step of the last accepting edge
    task automatic drain;
        i_valid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic test_linear_extremes;
        send_pixel(16'd0, 12'd0, 12'd0);
        send_pixel(16'hFFFF, 12'd1023, 12'd1023);
        send_pixel(16'h5A5A, 12'd1024, 12'd5);
        send_pixel(16'h1234, 12'd5, 12'hFFF);
        drain();
        write_reg(REG_GAIN, 64'hFFFF_0000);
        send_pixel(16'd100, 12'd3, 12'd3);
        drain();
        write_reg(REG_GAIN, 64'h7FFF_FFFF);
        write_reg(REG_OFFSET, 64'h7FFF_FFFF);
        send_pixel(16'hFFFF, 12'd10, 12'd10);
        send_pixel(16'd1, 12'd10, 12'd10);
        drain();
    endtask

    task automatic test_log_curve;
        write_reg(REG_LOG_ENABLE, 64'd1);
        write_reg(REG_GAIN, 64'd1);
        write_reg(REG_OFFSET, 64'd65535);
        send_pixel(16'd1, 12'd0, 12'd0);
        send_pixel(16'd2, 12'd0, 12'd0);
        drain();
        write_reg(REG_OFFSET, 64'd0);
        send_pixel(16'd0, 12'd7, 12'd7);
        send_pixel(16'd1, 12'd7, 12'd7);
        send_pixel(16'd32768, 12'd7, 12'd7);
        send_pixel(16'd4095, 12'd7, 12'd7);
        drain();
        write_reg(REG_OFFSET, 64'hFFFF_FFF0);
        send_pixel(16'd3, 12'd7, 12'd7);
        drain();
    endtask

    task automatic test_border_taper;
        write_reg(REG_LOG_ENABLE, 64'd0);
        write_reg(REG_GAIN, 64'd65536);
        write_reg(REG_OFFSET, 64'd0);
        write_reg(REG_IMAGE_WIDTH, 64'd4096);
        write_reg(REG_IMAGE_HEIGHT, 64'd8191);
        write_reg(REG_ZERO_WIDTHS, {16'd0, 12'd4, 12'd3, 12'd2, 12'd5});
        write_reg(REG_FEATHER_WIDTHS, {16'd0, 12'd20, 12'd1, 12'd4095, 12'd10});
        send_pixel(16'hFFFF, 12'd5, 12'd2000);
        send_pixel(16'hFFFF, 12'd9, 12'd2000);
        send_pixel(16'hFFFF, 12'd15, 12'd2000);
        send_pixel(16'hFFFF, 12'd4095, 12'd4095);
        send_pixel(16'hFFFF, 12'd2000, 12'd10);
        send_pixel(16'hFFFF, 12'd2000, 12'd0);
        drain();
        write_reg(REG_IMAGE_WIDTH, 64'd0);
        send_pixel(16'hFFFF, 12'd0, 12'd0);
        drain();
    endtask

    task automatic random_phase(int items);
        int w;
        int h;
        if ($urandom_range(0, 1)) begin
            write_reg(REG_LOG_ENABLE, 64'd1);
            write_reg(REG_GAIN, 64'($urandom_range(0, 8)));
            write_reg(REG_OFFSET, 64'($urandom_range(0, 70000)) - 64'd2000);
        end else begin
            write_reg(REG_LOG_ENABLE, 64'd0);
            write_reg(REG_GAIN, $urandom_range(0, 1) ? 64'($urandom) : 64'($urandom_range(0, 1 << 20)));
            write_reg(REG_OFFSET, {32'd0, $urandom});
        end
        case ($urandom_range(0, 3))
            0: w = 4096;
            1: w = $urandom_range(1, 64);
            2: w = $urandom_range(4097, 8191);
            default: w = $urandom_range(1, 4096);
        endcase
        h = $urandom_range(0, 1) ? 4096 : $urandom_range(1, 4096);
        write_reg(REG_IMAGE_WIDTH, 64'(w));
        write_reg(REG_IMAGE_HEIGHT, 64'(h));
        if ($urandom_range(0, 4) == 0) begin
            write_reg(REG_ZERO_WIDTHS, {$urandom, $urandom});
            write_reg(REG_FEATHER_WIDTHS, {$urandom, $urandom});
        end else begin
            write_reg(REG_ZERO_WIDTHS, {16'd0,
                                        12'($urandom_range(0, 15)), 12'($urandom_range(0, 15)),
                                        12'($urandom_range(0, 15)), 12'($urandom_range(0, 15))});
            write_reg(REG_FEATHER_WIDTHS, {16'd0,
                                           12'($urandom_range(0, 40)), 12'($urandom_range(0, 40)),
                                           12'($urandom_range(0, 40)), 12'($urandom_range(0, 40))});
        end
        if (w > 4096)
            w = 4096;
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_pixel(16'($urandom), 12'($urandom), 12'($urandom));
            else
                send_pixel(16'($urandom), 12'($urandom_range(0, w - 1)),
                           12'($urandom_range(0, h - 1)));
        end
        drain();
    endtask

    task automatic test_random_sweep;
        for (int ph = 0; ph < 7; ph++) begin
            idle_pct = (ph == 0) ? 0 : 15;
            random_phase(250);
        end
    endtask

    initial begin
        mismatches = 0;
        idle_pct = 15;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sh_gain = 32'sd65536;
        sh_offset = 32'sd0;
        sh_log = 1'b0;
        sh_width = 13'd1024;
        sh_height = 13'd1024;
        sh_zero = '0;
        sh_feather = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_linear_extremes();
        test_log_curve();
        test_border_taper();
        test_random_sweep();
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
